// ----- src/lap4_pkg.sv -----
`default_nettype none

package lap4_pkg;

    localparam int MAX_WIDTH = 512;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int PIX_W     = 8;
    localparam int COL_W     = 9;
    localparam int ROW_W     = 12;
    localparam int FW_W      = 10;
    localparam int FH_W      = 12;
    localparam int EDGE_W    = 10;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 10'd320;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 12'd320;
    localparam logic [FW_W-1:0] MIN_WIDTH        = 10'd3;
    localparam logic [FH_W-1:0] MIN_HEIGHT       = 12'd3;
    localparam logic [FW_W-1:0] MAX_WIDTH_V      = FW_W'(MAX_WIDTH);

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } lap4_in_t;

    typedef struct packed {
        logic [EDGE_W-1:0] edge_value;
        logic [ROW_W-1:0]  out_row;
        logic [COL_W-1:0]  out_col;
        logic              frame_last;
    } lap4_out_t;

    // write-back request to both line memories
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  two;
        logic [PIX_W-1:0]  one;
    } lap4_wr_t;

endpackage

`default_nettype wire

// ----- src/lap4_line_buf.sv -----
`default_nettype none

module lap4_line_buf
    import lap4_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    input  wire lap4_wr_t          wr,
    output logic      [PIX_W-1:0]  above2,
    output logic      [PIX_W-1:0]  above1
);

    logic [PIX_W-1:0] mem_two [MAX_WIDTH];
    logic [PIX_W-1:0] mem_one [MAX_WIDTH];

    logic [PIX_W-1:0] rd_two_reg;
    logic [PIX_W-1:0] rd_one_reg;
    logic [PIX_W-1:0] fwd_two_reg;
    logic [PIX_W-1:0] fwd_one_reg;
    logic             fwd_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem_two[wr.addr] <= wr.two;
            mem_one[wr.addr] <= wr.one;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_two_reg  <= mem_two[rd_addr];
            rd_one_reg  <= mem_one[rd_addr];
            fwd_two_reg <= wr.two;
            fwd_one_reg <= wr.one;
        end
    end

    // read and write to the same entry on one edge: take the written data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_reg <= wr.en && (wr.addr == rd_addr);
        end
    end

    assign above2 = fwd_reg ? fwd_two_reg : rd_two_reg;
    assign above1 = fwd_reg ? fwd_one_reg : rd_one_reg;

endmodule

`default_nettype wire

// ----- src/lap4_stencil.sv -----
`default_nettype none

module lap4_stencil
    import lap4_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    input  wire logic [PIX_W-1:0]  pixel,
    input  wire logic [PIX_W-1:0]  above2,
    input  wire logic [PIX_W-1:0]  above1,
    output logic      [EDGE_W-1:0] edge_value
);

    logic [PIX_W-1:0] down_reg;
    logic [PIX_W-1:0] centre_reg;
    logic [PIX_W-1:0] left_reg;
    logic [PIX_W-1:0] up_reg;

    logic signed [11:0] lap;
    logic signed [11:0] lap_abs;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            down_reg   <= '0;
            centre_reg <= '0;
            left_reg   <= '0;
            up_reg     <= '0;
        end else if (advance) begin
            left_reg   <= centre_reg;
            centre_reg <= above1;
            up_reg     <= above2;
            down_reg   <= pixel;
        end
    end

    // right neighbour is the line entry read for the current pixel
    always_comb begin
        lap = $signed({2'b00, centre_reg, 2'b00})
            - $signed({4'b0000, up_reg})
            - $signed({4'b0000, down_reg})
            - $signed({4'b0000, left_reg})
            - $signed({4'b0000, above1});
        lap_abs = lap[11] ? -lap : lap;
    end

    assign edge_value = lap_abs[EDGE_W-1:0];

endmodule

`default_nettype wire

// ----- src/laplacian_4_neighbour_filter.sv -----
// timing: the pixel diagonally below-right of a result's centre is accepted (line memory
//   read at that edge), then the result enters the output register once that is free
// throughput: one pixel per cycle while the output is not stalled, set by one read and
//   one write-back per line memory each cycle, with same-entry forwarding
// reset: position, window and output control cleared, geometry 320 x 320;
//   line memories are not cleared
`default_nettype none

module laplacian_4_neighbour_filter
    import lap4_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire lap4_in_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output lap4_out_t                 m_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    logic [FW_W-1:0]  frame_width_reg;
    logic [FH_W-1:0]  frame_height_reg;
    logic [ROW_W-1:0] row_pos_reg, row_pos_next;
    logic [COL_W-1:0] col_pos_reg, col_pos_next;

    logic             valid_a_reg;
    logic             res_a_reg;
    logic             last_a_reg;
    logic [PIX_W-1:0] px_a_reg;
    logic [ROW_W-1:0] row_a_reg;
    logic [COL_W-1:0] col_a_reg;
    logic [ADDR_W-1:0] addr_a_reg;

    logic      m_valid_reg;
    lap4_out_t m_data_reg;

    logic [FW_W-1:0]  w_eff;
    logic [FH_W-1:0]  h_eff;
    logic [ROW_W-1:0] r_in;
    logic [COL_W-1:0] c_in;
    logic [FW_W-1:0]  c_inc;
    logic [ROW_W:0]   r_inc;
    logic             res_in;
    logic             last_in;
    logic             accept;
    logic             out_free;
    logic             a_done;

    logic [PIX_W-1:0]  above2;
    logic [PIX_W-1:0]  above1;
    logic [EDGE_W-1:0] edge_value;
    lap4_wr_t          wr;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (frame_width_reg < MIN_WIDTH) begin
            w_eff = MIN_WIDTH;
        end else if (frame_width_reg > MAX_WIDTH_V) begin
            w_eff = MAX_WIDTH_V;
        end else begin
            w_eff = frame_width_reg;
        end
        h_eff = (frame_height_reg < MIN_HEIGHT) ? MIN_HEIGHT : frame_height_reg;
    end

    // position of the incoming pixel, the position after it, and its result and frame-last flags
    always_comb begin
        r_in  = s_data.frame_start ? '0 : row_pos_reg;
        c_in  = s_data.frame_start ? '0 : col_pos_reg;
        c_inc = {1'b0, c_in} + 1'b1;
        r_inc = {1'b0, r_in} + 1'b1;
        col_pos_next = c_in;
        row_pos_next = r_in;
        if (c_inc >= w_eff) begin
            col_pos_next = '0;
            row_pos_next = (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[ROW_W-1:0];
        end else begin
            col_pos_next = c_inc[COL_W-1:0];
        end
        res_in  = (r_in >= 12'd2) && (c_in >= 9'd2) && (r_in < h_eff)
               && ({1'b0, c_in} < w_eff);
        last_in = (r_in == h_eff - 1'b1) && ({1'b0, c_in} == w_eff - 1'b1);
    end

    assign out_free = !m_valid_reg || m_ready;
    assign a_done   = valid_a_reg && (!res_a_reg || out_free);
    assign s_ready  = !valid_a_reg || a_done;
    assign accept   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
            valid_a_reg <= 1'b0;
        end else begin
            if (accept) begin
                row_pos_reg <= row_pos_next;
                col_pos_reg <= col_pos_next;
                valid_a_reg <= 1'b1;
            end else if (a_done) begin
                valid_a_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_a_reg  <= res_in;
            last_a_reg <= last_in;
            px_a_reg   <= s_data.pixel;
            row_a_reg  <= r_in - 1'b1;
            col_a_reg  <= c_in - 1'b1;
            addr_a_reg <= c_in[ADDR_W-1:0];
        end
    end

    assign wr.en   = a_done;
    assign wr.addr = addr_a_reg;
    assign wr.two  = above1;
    assign wr.one  = px_a_reg;

    lap4_line_buf u_line_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (c_in[ADDR_W-1:0]),
        .wr      (wr),
        .above2  (above2),
        .above1  (above1)
    );

    lap4_stencil u_stencil (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (a_done),
        .pixel      (px_a_reg),
        .above2     (above2),
        .above1     (above1),
        .edge_value (edge_value)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (a_done && res_a_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_done && res_a_reg) begin
            m_data_reg.edge_value <= edge_value;
            m_data_reg.out_row    <= row_a_reg;
            m_data_reg.out_col    <= col_a_reg;
            m_data_reg.frame_last <= last_a_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.edge_value <= 10'd1020))
        else $error("edge value out of range");

    a_hold_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_a_reg && res_a_reg && !out_free) |=> valid_a_reg)
        else $error("pending pixel lost while output stalled");

    a_ready_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (valid_a_reg && m_valid_reg && !m_ready))
        else $error("input stalled without cause");

    a_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.out_row != 12'd0 && m_data_reg.out_col != 9'd0))
        else $error("result for a border pixel");

endmodule

`default_nettype wire
